// ===== sv/cbst_pkg.sv =====
// Shared types and constants for the cubic B-spline segment tessellator.
// No dependencies; used by cbst_ctrl, cbst_dp and the top level.
package cbst_pkg;

  localparam int COORD_BITS_D = 12;
  localparam int MAX_STEPS_D  = 64;
  localparam int FRAC_BITS_D  = 16;
  localparam int STEP_W       = 7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_HNORM,
    OP_SQRT,
    OP_DIV,
    OP_T2,
    OP_T3,
    OP_WGT,
    OP_MAC,
    OP_RND,
    OP_FIX,
    OP_NEXT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HNORM,
    ST_SQRT,
    ST_DIV,
    ST_T2,
    ST_T3,
    ST_WGT,
    ST_MAC,
    ST_RND,
    ST_FIX,
    ST_NEXT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic seg_done;
  } status_t;

endpackage

// ===== sv/cbst_ctrl.sv =====
// Sequencing state machine of the tessellator.
// Depends on cbst_pkg; drives cbst_dp through cmd_t and reads status_t.
module cbst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output cbst_pkg::cmd_t   cmd,
  input  cbst_pkg::status_t sts
);

  cbst_pkg::state_t state_r, state_nxt;
  logic [1:0] tap_r, tap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbst_pkg::ST_IDLE;
      tap_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cmd.op    = cbst_pkg::OP_NONE;
    cmd.tap   = tap_r;
    busy      = (state_r != cbst_pkg::ST_IDLE);
    case (state_r)
      cbst_pkg::ST_IDLE: begin
        tap_nxt = 2'd0;
        if (start) begin
          cmd.op    = cbst_pkg::OP_LOAD;
          state_nxt = cbst_pkg::ST_HNORM;
        end
      end
      cbst_pkg::ST_HNORM: begin
        cmd.op    = cbst_pkg::OP_HNORM;
        state_nxt = cbst_pkg::ST_SQRT;
      end
      cbst_pkg::ST_SQRT: begin
        cmd.op = cbst_pkg::OP_SQRT;
        if (sts.sqrt_done) state_nxt = cbst_pkg::ST_DIV;
      end
      cbst_pkg::ST_DIV: begin
        cmd.op = cbst_pkg::OP_DIV;
        if (sts.div_done) state_nxt = cbst_pkg::ST_T2;
      end
      cbst_pkg::ST_T2: begin
        cmd.op    = cbst_pkg::OP_T2;
        state_nxt = cbst_pkg::ST_T3;
      end
      cbst_pkg::ST_T3: begin
        cmd.op    = cbst_pkg::OP_T3;
        state_nxt = cbst_pkg::ST_WGT;
      end
      cbst_pkg::ST_WGT: begin
        cmd.op    = cbst_pkg::OP_WGT;
        tap_nxt   = 2'd0;
        state_nxt = cbst_pkg::ST_MAC;
      end
      cbst_pkg::ST_MAC: begin
        cmd.op  = cbst_pkg::OP_MAC;
        tap_nxt = tap_r + 2'd1;
        if (tap_r == 2'd3) state_nxt = cbst_pkg::ST_RND;
      end
      cbst_pkg::ST_RND: begin
        cmd.op    = cbst_pkg::OP_RND;
        state_nxt = cbst_pkg::ST_FIX;
      end
      cbst_pkg::ST_FIX: begin
        cmd.op    = cbst_pkg::OP_FIX;
        state_nxt = cbst_pkg::ST_NEXT;
      end
      cbst_pkg::ST_NEXT: begin
        cmd.op    = cbst_pkg::OP_NEXT;
        state_nxt = sts.seg_done ? cbst_pkg::ST_IDLE : cbst_pkg::ST_T2;
      end
      default: begin
        state_nxt = cbst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/cbst_dp.sv =====
// Datapath: curvature norm, step count search, S/n divider, basis blend and rounding.
// Depends on cbst_pkg; commanded by cbst_ctrl.
module cbst_dp #(
  parameter int COORD_BITS = cbst_pkg::COORD_BITS_D,
  parameter int MAX_STEPS  = cbst_pkg::MAX_STEPS_D,
  parameter int FRAC_BITS  = cbst_pkg::FRAC_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbst_pkg::cmd_t                cmd,
  output cbst_pkg::status_t             sts,
  input  logic signed [COORD_BITS-1:0]  in_p0_x,
  input  logic signed [COORD_BITS-1:0]  in_p0_y,
  input  logic signed [COORD_BITS-1:0]  in_p1_x,
  input  logic signed [COORD_BITS-1:0]  in_p1_y,
  input  logic signed [COORD_BITS-1:0]  in_p2_x,
  input  logic signed [COORD_BITS-1:0]  in_p2_y,
  input  logic signed [COORD_BITS-1:0]  in_p3_x,
  input  logic signed [COORD_BITS-1:0]  in_p3_y,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_from_x,
  output logic signed [COORD_BITS-1:0]  out_from_y,
  output logic signed [COORD_BITS-1:0]  out_to_x,
  output logic signed [COORD_BITS-1:0]  out_to_y,
  output logic [cbst_pkg::STEP_W-1:0]   out_step_index,
  output logic [cbst_pkg::STEP_W-1:0]   out_step_count,
  output logic                          out_clamped,
  output logic                          out_last_piece
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SW   = cbst_pkg::STEP_W;
  localparam int VW   = C + 5;
  localparam int CMPW = (VW > 2 * SW) ? VW : 2 * SW;
  localparam int CW   = $clog2(F + 1);
  localparam int WW   = F + 4;
  localparam int AW   = F + C + 6;
  localparam int YW   = C + 4;
  localparam int K    = C + 6;
  localparam int QW   = YW - 1;
  localparam logic [K-2:0]         RECIP   = (K-1)'((1 << K) / 3);
  localparam logic signed [WW-1:0] ONE_S   = WW'(1) << F;
  localparam logic signed [AW-1:0] RND_OFF = AW'(3) << F;
  localparam logic [YW-1:0]        Y_OFF   = YW'(3) << (C + 1);
  localparam logic signed [C+4:0]  Q_OFF   = (C+5)'(1) << (C + 1);
  localparam logic signed [C+4:0]  PT_MAX  = (C+5)'((1 << (C - 1)) - 1);
  localparam logic signed [C+4:0]  PT_MIN  = -((C+5)'(1) << (C - 1));

  logic signed [C-1:0]  c_r   [2][4];
  logic [VW-1:0]        v_r;
  logic [SW-1:0]        r_r;
  logic [SW-1:0]        n_r;
  logic                 clamp_r;
  logic [SW-1:0]        rem_r;
  logic [F:0]           qs_r;
  logic [CW-1:0]        div_cnt_r;
  logic [F:0]           t_r, t2_r, t3_r;
  logic [SW-1:0]        trem_r;
  logic [SW-1:0]        k_r;
  logic signed [WW-1:0] w_r   [4];
  logic signed [AW-1:0] acc_r [2];
  logic [YW-1:0]        y_r   [2];
  logic [QW-1:0]        q0_r  [2];
  logic signed [C-1:0]  cur_r [2];
  logic signed [C-1:0]  prev_r[2];
  logic                 out_valid_r;

  // curvature norm
  logic signed [C+2:0] d0 [2], d1 [2];
  logic [C+1:0]        a0 [2], a1 [2];
  logic [C+2:0]        h0, h1, hmax;
  logic [VW-1:0]       v_nxt;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      d0[a] = (C+3)'(c_r[a][0]) - ((C+3)'(c_r[a][1]) <<< 1) + (C+3)'(c_r[a][2]);
      d1[a] = (C+3)'(c_r[a][1]) - ((C+3)'(c_r[a][2]) <<< 1) + (C+3)'(c_r[a][3]);
      a0[a] = (d0[a] < 0) ? (C+2)'(-d0[a]) : (C+2)'(d0[a]);
      a1[a] = (d1[a] < 0) ? (C+2)'(-d1[a]) : (C+2)'(d1[a]);
    end
    h0    = (C+3)'(a0[0]) + (C+3)'(a0[1]);
    h1    = (C+3)'(a1[0]) + (C+3)'(a1[1]);
    hmax  = (h0 > h1) ? h0 : h1;
    v_nxt = VW'(hmax) + (VW'(hmax) << 1);
  end

  // step count search: smallest r with r*r >= 3H
  logic [2*SW-1:0] sq;
  logic            sq_ok;
  assign sq    = r_r * r_r;
  assign sq_ok = CMPW'(sq) >= CMPW'(v_r);

  // restoring divider for S / n
  logic [SW:0]   rem_sh;
  logic          q_bit;
  logic [SW:0]   rem_sub;
  assign rem_sh  = {rem_r, (div_cnt_r == CW'(F))};
  assign q_bit   = rem_sh >= {1'b0, n_r};
  assign rem_sub = rem_sh - {1'b0, n_r};

  // parameter advance
  logic [F:0]  t_sum;
  logic [SW:0] trem_sum;
  logic [SW:0] trem_wrap;
  logic        t_carry;
  assign t_sum     = t_r + qs_r;
  assign trem_sum  = {1'b0, trem_r} + {1'b0, rem_r};
  assign trem_wrap = trem_sum - {1'b0, n_r};
  assign t_carry   = trem_sum >= {1'b0, n_r};

  // shared power multiplier
  logic [F:0]       mul_a;
  logic [2*F+1:0]   pt;
  assign mul_a = (cmd.op == cbst_pkg::OP_T3) ? t2_r : t_r;
  assign pt    = mul_a * t_r;

  // basis weights
  logic signed [WW-1:0] ts, t2s, t3s;
  logic signed [WW-1:0] w_nxt [4];
  always_comb begin
    ts  = $signed(WW'(t_r));
    t2s = $signed(WW'(t2_r));
    t3s = $signed(WW'(t3_r));
    w_nxt[0] = ONE_S - ((ts <<< 1) + ts) + ((t2s <<< 1) + t2s) - t3s;
    w_nxt[1] = ((t3s <<< 1) + t3s) - ((t2s <<< 2) + (t2s <<< 1)) + (ONE_S <<< 2);
    w_nxt[2] = ((t2s <<< 1) + t2s) - ((t3s <<< 1) + t3s) + ((ts <<< 1) + ts) + ONE_S;
    w_nxt[3] = t3s;
  end

  // blend, rounding, divide by three, saturation
  logic signed [WW+C-1:0] mprod [2];
  logic signed [AW-1:0]   sh    [2];
  logic [YW-1:0]          y_nxt [2];
  logic [YW+K-2:0]        qp    [2];
  logic [YW-1:0]          rr    [2];
  logic [QW-1:0]          qf    [2];
  logic signed [C+4:0]    qv    [2];
  logic signed [C-1:0]    pt_nxt[2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mprod[a] = w_r[cmd.tap] * c_r[a][cmd.tap];
      sh[a]    = (acc_r[a] + RND_OFF) >>> (F + 1);
      y_nxt[a] = sh[a][YW-1:0] + Y_OFF;
      qp[a]    = y_nxt[a] * RECIP;
      rr[a]    = y_r[a] - ((YW'(q0_r[a]) << 1) + YW'(q0_r[a]));
      qf[a]    = (rr[a] >= YW'(3)) ? q0_r[a] + QW'(1) : q0_r[a];
      qv[a]    = $signed((C+5)'(qf[a])) - Q_OFF;
      if (qv[a] > PT_MAX)      pt_nxt[a] = PT_MAX[C-1:0];
      else if (qv[a] < PT_MIN) pt_nxt[a] = PT_MIN[C-1:0];
      else                     pt_nxt[a] = qv[a][C-1:0];
    end
  end

  assign sts.sqrt_done = sq_ok || (r_r == SW'(MAX_STEPS - 1));
  assign sts.div_done  = (div_cnt_r == CW'(0));
  assign sts.seg_done  = (k_r == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == cbst_pkg::OP_NEXT) && (k_r != SW'(0));
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cbst_pkg::OP_LOAD: begin
        c_r[0][0] <= in_p0_x;
        c_r[1][0] <= in_p0_y;
        c_r[0][1] <= in_p1_x;
        c_r[1][1] <= in_p1_y;
        c_r[0][2] <= in_p2_x;
        c_r[1][2] <= in_p2_y;
        c_r[0][3] <= in_p3_x;
        c_r[1][3] <= in_p3_y;
      end
      cbst_pkg::OP_HNORM: begin
        v_r <= v_nxt;
        r_r <= '0;
      end
      cbst_pkg::OP_SQRT: begin
        r_r <= r_r + SW'(1);
        if (sq_ok) begin
          n_r     <= r_r + SW'(1);
          clamp_r <= 1'b0;
        end else begin
          n_r     <= SW'(MAX_STEPS);
          clamp_r <= 1'b1;
        end
        rem_r     <= '0;
        qs_r      <= '0;
        div_cnt_r <= CW'(F);
      end
      cbst_pkg::OP_DIV: begin
        rem_r <= q_bit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
        qs_r  <= {qs_r[F-1:0], q_bit};
        if (div_cnt_r != CW'(0)) begin
          div_cnt_r <= div_cnt_r - CW'(1);
        end else begin
          t_r    <= '0;
          trem_r <= n_r >> 1;
          k_r    <= '0;
        end
      end
      cbst_pkg::OP_T2: t2_r <= pt[2*F:F];
      cbst_pkg::OP_T3: t3_r <= pt[2*F:F];
      cbst_pkg::OP_WGT: begin
        for (int j = 0; j < 4; j++) w_r[j] <= w_nxt[j];
      end
      cbst_pkg::OP_MAC: begin
        for (int a = 0; a < 2; a++) begin
          if (cmd.tap == 2'd0) acc_r[a] <= AW'(mprod[a]);
          else                 acc_r[a] <= acc_r[a] + AW'(mprod[a]);
        end
      end
      cbst_pkg::OP_RND: begin
        for (int a = 0; a < 2; a++) begin
          y_r[a]  <= y_nxt[a];
          q0_r[a] <= qp[a][YW+K-2:K];
        end
      end
      cbst_pkg::OP_FIX: begin
        for (int a = 0; a < 2; a++) cur_r[a] <= pt_nxt[a];
      end
      cbst_pkg::OP_NEXT: begin
        for (int a = 0; a < 2; a++) prev_r[a] <= cur_r[a];
        if (k_r != SW'(0)) begin
          out_from_x     <= prev_r[0];
          out_from_y     <= prev_r[1];
          out_to_x       <= cur_r[0];
          out_to_y       <= cur_r[1];
          out_step_index <= k_r;
          out_step_count <= n_r;
          out_clamped    <= clamp_r;
          out_last_piece <= (k_r == n_r);
        end
        if (k_r != n_r) begin
          k_r    <= k_r + SW'(1);
          t_r    <= t_sum + (F+1)'(t_carry);
          trem_r <= t_carry ? trem_wrap[SW-1:0] : trem_sum[SW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/cubic_bspline_segment_tessellator_top.sv =====
// Top level of the uniform cubic B-spline segment tessellator.
// Depends on cbst_pkg, cbst_ctrl and cbst_dp.
//
// One item (four control points) is taken when start is high and busy is low. The block
// then emits n line pieces, one per out_valid pulse; the receiver cannot stall them, so
// out_valid must be sampled every cycle. An item goes through setup (load and curvature
// norm), the step count search, which tries one candidate at a time (n candidates, at most
// MAX_STEPS), the bit-serial S/n divider for FRAC_BITS+1 quotient bits, and then n+1 curve
// points on the shared multiply-accumulate datapath, each through T2, T3, WGT, one MAC per
// control point, RND, FIX and NEXT. busy falls right after the last piece is issued.
module cubic_bspline_segment_tessellator_top #(
  parameter int COORD_BITS = cbst_pkg::COORD_BITS_D,
  parameter int MAX_STEPS  = cbst_pkg::MAX_STEPS_D,
  parameter int FRAC_BITS  = cbst_pkg::FRAC_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_p0_x,
  input  logic signed [COORD_BITS-1:0]  in_p0_y,
  input  logic signed [COORD_BITS-1:0]  in_p1_x,
  input  logic signed [COORD_BITS-1:0]  in_p1_y,
  input  logic signed [COORD_BITS-1:0]  in_p2_x,
  input  logic signed [COORD_BITS-1:0]  in_p2_y,
  input  logic signed [COORD_BITS-1:0]  in_p3_x,
  input  logic signed [COORD_BITS-1:0]  in_p3_y,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_from_x,
  output logic signed [COORD_BITS-1:0]  out_from_y,
  output logic signed [COORD_BITS-1:0]  out_to_x,
  output logic signed [COORD_BITS-1:0]  out_to_y,
  output logic [cbst_pkg::STEP_W-1:0]   out_step_index,
  output logic [cbst_pkg::STEP_W-1:0]   out_step_count,
  output logic                          out_clamped,
  output logic                          out_last_piece
);

  cbst_pkg::cmd_t    cmd;
  cbst_pkg::status_t sts;

  cbst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  cbst_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_STEPS  (MAX_STEPS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_p0_x        (in_p0_x),
    .in_p0_y        (in_p0_y),
    .in_p1_x        (in_p1_x),
    .in_p1_y        (in_p1_y),
    .in_p2_x        (in_p2_x),
    .in_p2_y        (in_p2_y),
    .in_p3_x        (in_p3_x),
    .in_p3_y        (in_p3_y),
    .out_valid      (out_valid),
    .out_from_x     (out_from_x),
    .out_from_y     (out_from_y),
    .out_to_x       (out_to_x),
    .out_to_y       (out_to_y),
    .out_step_index (out_step_index),
    .out_step_count (out_step_count),
    .out_clamped    (out_clamped),
    .out_last_piece (out_last_piece)
  );

endmodule
